FILE: sv/isms_pkg.sv
// Shared types, constants and register codes for the Ising Metropolis spin update block.
package isms_pkg;

  // Default lattice geometry
  localparam int SIDE_DEF = 64;
  localparam int DIM_DEF  = 2;

  // Field widths
  localparam int SITE_W    = 12;
  localparam int RAND_W    = 32;
  localparam int FIELD_W   = 16;
  localparam int WORD_W    = 32;
  localparam int SUM_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int NUM_COUP  = 5;

  // 1.0 in UQ8.24
  localparam logic [WORD_W-1:0] ONE_Q824 = 32'h0100_0000;

  // Configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD      = 3'd0,
    REG_COUPLING_0 = 3'd1,
    REG_COUPLING_1 = 3'd2,
    REG_COUPLING_2 = 3'd3,
    REG_COUPLING_3 = 3'd4,
    REG_COUPLING_4 = 3'd5,
    REG_FIELD_DOWN = 3'd6,
    REG_FIELD_UP   = 3'd7
  } cfg_reg_t;

  // Live configuration handed to the decision logic
  typedef struct packed {
    logic signed [FIELD_W-1:0]          field;
    logic [NUM_COUP-1:0][WORD_W-1:0]    coupling;
    logic [WORD_W-1:0]                  field_down;
    logic [WORD_W-1:0]                  field_up;
  } cfg_t;

  // Per-item result of the decision logic
  typedef struct packed {
    logic                    flipped;
    logic                    new_spin;
    logic signed [SUM_W-1:0] nsum;
  } dec_res_t;

endpackage

FILE: sv/isms_ram.sv
// Generic single-write, single-read RAM with registered (read-first) output.
module isms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/isms_spin_store.sv
// Spin lattice store: three row-wide RAM copies, post-reset clear pass, write forwarding.
module isms_spin_store import isms_pkg::*; #(
  parameter int SIDE = SIDE_DEF,
  parameter int DIM  = DIM_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          rd_en,
  input  logic [(DIM == 1 ? 1 : $clog2(SIDE))-1:0]      rd_row_up,
  input  logic [(DIM == 1 ? 1 : $clog2(SIDE))-1:0]      rd_row,
  input  logic [(DIM == 1 ? 1 : $clog2(SIDE))-1:0]      rd_row_dn,
  input  logic                                          wr_en,
  input  logic [(DIM == 1 ? 1 : $clog2(SIDE))-1:0]      wr_row,
  input  logic [SIDE-1:0]                               wr_data,
  output logic [SIDE-1:0]                               data_up,
  output logic [SIDE-1:0]                               data_cur,
  output logic [SIDE-1:0]                               data_dn,
  output logic                                          busy
);

  localparam int NUM_ROWS = (DIM == 1) ? 1 : SIDE;
  localparam int ROW_W    = (DIM == 1) ? 1 : $clog2(SIDE);

  logic [ROW_W-1:0]           clr_row;
  logic                       ram_we;
  logic [ROW_W-1:0]           ram_waddr;
  logic [SIDE-1:0]            ram_wdata;
  logic [2:0][ROW_W-1:0]      raddr;
  logic [2:0][ROW_W-1:0]      raddr_q;
  logic [2:0][SIDE-1:0]       rdata;
  logic [2:0][SIDE-1:0]       fwd;
  logic                       lw_valid;
  logic [ROW_W-1:0]           lw_row;
  logic [SIDE-1:0]            lw_data;

  // clear pass: one row of all-up spins per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      if (clr_row == ROW_W'(NUM_ROWS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  // shared write port for all copies
  assign ram_we    = busy || wr_en;
  assign ram_waddr = busy ? clr_row : wr_row;
  assign ram_wdata = busy ? '1 : wr_data;

  assign raddr[0] = rd_row_up;
  assign raddr[1] = rd_row;
  assign raddr[2] = rd_row_dn;

  // one copy per row that an item reads
  for (genvar gi = 0; gi < 3; gi++) begin : g_copy
    isms_ram #(
      .WIDTH (SIDE),
      .DEPTH (NUM_ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (rd_en),
      .raddr (raddr[gi]),
      .rdata (rdata[gi])
    );
  end

  // track read addresses alongside the RAM output registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      raddr_q <= raddr;
    end
  end

  // most recent row write, always the newest content of that row
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (wr_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_row  <= wr_row;
      lw_data <= wr_data;
    end
  end

  // forward a write that landed on the same edge as the read
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fwd[i] = (lw_valid && (lw_row == raddr_q[i])) ? lw_data : rdata[i];
    end
  end

  assign data_up  = fwd[0];
  assign data_cur = fwd[1];
  assign data_dn  = fwd[2];

endmodule

FILE: sv/isms_decide.sv
// Neighbour sum, energy test and Metropolis acceptance for one site.
module isms_decide import isms_pkg::*; #(
  parameter int SIDE = SIDE_DEF,
  parameter int DIM  = DIM_DEF
) (
  input  logic [SIDE-1:0]             row_up,
  input  logic [SIDE-1:0]             row_cur,
  input  logic [SIDE-1:0]             row_dn,
  input  logic [$clog2(SIDE)-1:0]     col,
  input  logic [RAND_W-1:0]           rnd,
  input  cfg_t                        cfg,
  output dec_res_t                    res,
  output logic [SIDE-1:0]             wr_row
);

  localparam int COL_W = $clog2(SIDE);
  localparam int T_W   = 18;

  logic                     s_up;
  logic                     nb_right;
  logic                     nb_left;
  logic                     nb_vert_up;
  logic                     nb_vert_dn;
  logic [2:0]               ups;
  logic signed [SUM_W-1:0]  nsum;
  logic signed [T_W-1:0]    t;
  logic                     energy_ok;
  logic [2:0]               k;
  logic [WORD_W-1:0]        cw;
  logic [WORD_W-1:0]        fw;
  logic [2*WORD_W-1:0]      prod;
  logic                     rand_ok;
  logic                     flip;

  // neighbour spins with helical wrap along the row
  always_comb begin
    s_up = row_cur[col];
    if (col == COL_W'(SIDE - 1)) begin
      nb_right = (DIM == 1) ? row_cur[0] : row_up[0];
    end else begin
      nb_right = row_cur[COL_W'(col + 1'b1)];
    end
    if (col == '0) begin
      nb_left = (DIM == 1) ? row_cur[SIDE-1] : row_dn[SIDE-1];
    end else begin
      nb_left = row_cur[COL_W'(col - 1'b1)];
    end
    nb_vert_up = (DIM == 1) ? 1'b0 : row_up[col];
    nb_vert_dn = (DIM == 1) ? 1'b0 : row_dn[col];
  end

  // sum of +-1 spins = 2 * (up count) - 2 * DIM
  assign ups  = 3'(nb_right) + 3'(nb_left) + 3'(nb_vert_up) + 3'(nb_vert_dn);
  assign nsum = SUM_W'({ups, 1'b0}) - SUM_W'(2 * DIM);

  // energy test on t = sum * 256 + field
  assign t = {{(T_W - SUM_W - 8){nsum[SUM_W-1]}}, nsum, 8'b0}
           + {{(T_W - FIELD_W){cfg.field[FIELD_W-1]}}, cfg.field};
  assign energy_ok = s_up ? (t[T_W-1] || (t == '0)) : !t[T_W-1];

  // coupling index: DIM - s*sum/2 reduces to a count of anti-aligned neighbours
  assign k    = s_up ? (3'(2 * DIM) - ups) : ups;
  assign cw   = cfg.coupling[k];
  assign fw   = s_up ? cfg.field_up : cfg.field_down;
  assign prod = (2*WORD_W)'(cw) * (2*WORD_W)'(fw);

  // random fraction widened to UQ16.48
  assign rand_ok = {16'b0, rnd, 16'b0} <= prod;
  assign flip    = energy_ok || rand_ok;

  assign res.flipped  = flip;
  assign res.new_spin = s_up ^ flip;
  assign res.nsum     = nsum;

  // row image with the site's new spin
  always_comb begin
    wr_row      = row_cur;
    wr_row[col] = s_up ^ flip;
  end

endmodule

FILE: sv/ising_metropolis_spin_update_top.sv
// Top level of the Ising Metropolis single-spin-flip update block.
// Takes one proposal (site, random fraction) per clock while no stage is stalled and
// returns one result per proposal: the accepting edge loads the input register, then
// the quotients by SIDE and by the volume are registered, the site's row and column
// are decoded from them while the rows are read from the spin store, and the decision
// goes into the result register, with a flipped site written back. The lattice lives in
// three row-wide RAM copies, one per row an item needs (its own and the two
// adjacent rows), so all neighbours come from one registered read. After reset the
// store runs a clearing pass of SIDE rows (one row when DIM is 1), one row per
// cycle, during which in_ready stays low; configuration writes take effect on the
// next edge and belong to times when no item is in flight. Sites at or beyond
// SIDE^DIM are reduced modulo the lattice volume.
module ising_metropolis_spin_update_top import isms_pkg::*; #(
  parameter int SIDE = SIDE_DEF,
  parameter int DIM  = DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SITE_W-1:0]        site,
  input  logic [RAND_W-1:0]        random_fraction,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     flipped,
  output logic                     new_spin,
  output logic signed [SUM_W-1:0]  neighbour_sum,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_wr_data
);

  localparam int VOLUME   = (DIM == 1) ? SIDE : SIDE * SIDE;
  localparam int NUM_ROWS = (DIM == 1) ? 1 : SIDE;
  localparam int COL_W    = $clog2(SIDE);
  localparam int ROW_W    = (DIM == 1) ? 1 : COL_W;
  localparam int M_W      = SITE_W + 1;
  localparam int QP_W     = SITE_W + M_W;
  localparam int PW       = SITE_W + COL_W + 1;
  // exact reciprocals: floor(x / d) = (x * ceil(2^s / d)) >> s for 12-bit x
  localparam int SH_SIDE  = SITE_W + $clog2(SIDE);
  localparam int SH_VOL   = SITE_W + $clog2(VOLUME);
  localparam longint M_SIDE = ((64'd1 << SH_SIDE) + SIDE - 1) / SIDE;
  localparam longint M_VOL  = ((64'd1 << SH_VOL) + VOLUME - 1) / VOLUME;

  // configuration
  cfg_t                cfg;

  // pipeline stage registers
  logic                a_valid;
  logic [SITE_W-1:0]   a_site;
  logic [RAND_W-1:0]   a_rnd;
  logic                b_valid;
  logic [SITE_W-1:0]   b_site;
  logic [SITE_W-1:0]   b_qs;
  logic [SITE_W-1:0]   b_qv;
  logic [RAND_W-1:0]   b_rnd;
  logic                c_valid;
  logic [ROW_W-1:0]    c_row;
  logic [COL_W-1:0]    c_col;
  logic [RAND_W-1:0]   c_rnd;

  // flow control
  logic                in_fire;
  logic                d_free;
  logic                c_adv;
  logic                c_free;
  logic                b_adv;
  logic                b_free;
  logic                a_free;
  logic                clear_busy;

  // datapath
  logic [QP_W-1:0]     prod_side;
  logic [QP_W-1:0]     prod_vol;
  logic [PW-1:0]       col_full;
  logic [PW-1:0]       row_full;
  logic [COL_W-1:0]    b_col;
  logic [ROW_W-1:0]    b_row;
  logic [ROW_W-1:0]    b_row_up;
  logic [ROW_W-1:0]    b_row_dn;
  logic [SIDE-1:0]     data_up;
  logic [SIDE-1:0]     data_cur;
  logic [SIDE-1:0]     data_dn;
  logic [SIDE-1:0]     wr_row_data;
  logic                wr_en;
  dec_res_t            res;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field      <= '0;
      cfg.coupling   <= {NUM_COUP{ONE_Q824}};
      cfg.field_down <= ONE_Q824;
      cfg.field_up   <= ONE_Q824;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index)) inside
        REG_FIELD: begin
          cfg.field <= cfg_wr_data[FIELD_W-1:0];
        end
        REG_COUPLING_0, REG_COUPLING_1, REG_COUPLING_2, REG_COUPLING_3,
        REG_COUPLING_4: begin
          cfg.coupling[3'(cfg_index - 1'b1)] <= cfg_wr_data;
        end
        REG_FIELD_DOWN: begin
          cfg.field_down <= cfg_wr_data;
        end
        REG_FIELD_UP: begin
          cfg.field_up <= cfg_wr_data;
        end
      endcase
    end
  end

  // stall chain from the result register back to the input
  assign d_free   = !out_valid || out_ready;
  assign c_adv    = c_valid && d_free;
  assign c_free   = !c_valid || d_free;
  assign b_adv    = b_valid && c_free;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free && !clear_busy;
  assign in_fire  = in_valid && in_ready;

  // stage A: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_site <= site;
      a_rnd  <= random_fraction;
    end
  end

  // quotients by SIDE and by the volume
  assign prod_side = QP_W'(a_site) * QP_W'(M_SIDE);
  assign prod_vol  = QP_W'(a_site) * QP_W'(M_VOL);

  // stage B: quotients
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_free) begin
      b_site <= a_site;
      b_qs   <= SITE_W'(prod_side >> SH_SIDE);
      b_qv   <= SITE_W'(prod_vol >> SH_VOL);
      b_rnd  <= a_rnd;
    end
  end

  // column and row of the site within the lattice, plus adjacent rows
  assign col_full = PW'(b_site) - PW'(b_qs) * PW'(SIDE);
  assign row_full = PW'(b_qs) - PW'(b_qv) * PW'(SIDE);
  assign b_col    = col_full[COL_W-1:0];
  assign b_row    = (DIM == 1) ? '0 : row_full[ROW_W-1:0];
  assign b_row_up = (b_row == ROW_W'(NUM_ROWS - 1)) ? '0 : ROW_W'(b_row + 1'b1);
  assign b_row_dn = (b_row == '0) ? ROW_W'(NUM_ROWS - 1) : ROW_W'(b_row - 1'b1);

  // spin store, read as B advances, written as C retires a flipped site
  isms_spin_store #(
    .SIDE (SIDE),
    .DIM  (DIM)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (b_adv),
    .rd_row_up (b_row_up),
    .rd_row    (b_row),
    .rd_row_dn (b_row_dn),
    .wr_en     (wr_en),
    .wr_row    (c_row),
    .wr_data   (wr_row_data),
    .data_up   (data_up),
    .data_cur  (data_cur),
    .data_dn   (data_dn),
    .busy      (clear_busy)
  );

  // stage C: decision
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_row <= b_row;
      c_col <= b_col;
      c_rnd <= b_rnd;
    end
  end

  isms_decide #(
    .SIDE (SIDE),
    .DIM  (DIM)
  ) u_decide (
    .row_up  (data_up),
    .row_cur (data_cur),
    .row_dn  (data_dn),
    .col     (c_col),
    .rnd     (c_rnd),
    .cfg     (cfg),
    .res     (res),
    .wr_row  (wr_row_data)
  );

  assign wr_en = c_adv && res.flipped;

  // stage D: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_free) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      flipped       <= res.flipped;
      new_spin      <= res.new_spin;
      neighbour_sum <= res.nsum;
    end
  end

`ifndef ASSERT_OFF
  // the store is written only by an item leaving the decision stage
  a_wr_retire: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (c_valid && d_free))
    else $error("spin store written without a retiring item");

  // no item is in flight while the clear pass runs
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> (!a_valid && !b_valid && !c_valid))
    else $error("item in flight during clear pass");

  // a sum of an even count of +-1 spins is even
  a_sum_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !neighbour_sum[0])
    else $error("odd neighbour sum");

  // a retired item lands in the result register on the next edge
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    c_adv |=> (out_valid && (flipped == $past(res.flipped))
               && (new_spin == $past(res.new_spin))))
    else $error("result register missed a retired item");
`endif

endmodule
